>>> rtl/amc_pkg.sv
// Package: shared widths, command codes and the microcode program of the connectivity block.
package amc_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 32;
  localparam int unsigned CMD_W            = 2;
  localparam int unsigned VTX_W            = 5;
  localparam int unsigned VC_W             = 6;
  localparam int unsigned EDGE_W           = 9;
  localparam int unsigned PC_W             = 4;
  localparam int unsigned VC_RESET         = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CHECK  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RD_A,
    RD_B,
    RD_V
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_A,
    WR_B
  } wr_sel_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_EDGE,
    EMIT_ERR,
    EMIT_CONN
  } emit_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOSTART,
    C_CHECK,
    C_ERR,
    C_MORE,
    C_CHANGED
  } cond_t;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    edge_eval;
    logic    chk_init;
    logic    sweep_acc;
    logic    chg_clr;
    emit_t   emit;
    cond_t   cond;
    pc_t     target;
  } ctl_word_t;

  localparam pc_t S_IDLE = 4'd0;
  localparam pc_t S_DISP = 4'd1;
  localparam pc_t S_RNG  = 4'd2;
  localparam pc_t S_E0   = 4'd3;
  localparam pc_t S_E1   = 4'd4;
  localparam pc_t S_E2   = 4'd5;
  localparam pc_t S_ERRS = 4'd6;
  localparam pc_t S_CHK0 = 4'd7;
  localparam pc_t S_SW0  = 4'd8;
  localparam pc_t S_SW1  = 4'd9;
  localparam pc_t S_SW2  = 4'd10;
  localparam pc_t S_DONE = 4'd11;

  function automatic ctl_word_t ucode(input pc_t pc);
    ctl_word_t w;
    w = '{rd_sel: RD_A, wr_sel: WR_NONE, edge_eval: 1'b0, chk_init: 1'b0,
          sweep_acc: 1'b0, chg_clr: 1'b0, emit: EMIT_NONE, cond: C_NEVER,
          target: S_IDLE};
    unique case (pc)
      S_IDLE: begin
        w.cond   = C_NOSTART;
        w.target = S_IDLE;
      end
      S_DISP: begin
        w.cond   = C_CHECK;
        w.target = S_CHK0;
      end
      S_RNG: begin
        w.cond   = C_ERR;
        w.target = S_ERRS;
      end
      S_E0: begin
        w.rd_sel = RD_A;
      end
      S_E1: begin
        w.rd_sel    = RD_B;
        w.wr_sel    = WR_A;
        w.edge_eval = 1'b1;
      end
      S_E2: begin
        w.wr_sel = WR_B;
        w.emit   = EMIT_EDGE;
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
      S_ERRS: begin
        w.emit   = EMIT_ERR;
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
      S_CHK0: begin
        w.chk_init = 1'b1;
      end
      S_SW0: begin
        w.rd_sel = RD_V;
      end
      S_SW1: begin
        w.sweep_acc = 1'b1;
        w.cond      = C_MORE;
        w.target    = S_SW0;
      end
      S_SW2: begin
        w.chg_clr = 1'b1;
        w.cond    = C_CHANGED;
        w.target  = S_SW0;
      end
      S_DONE: begin
        w.emit   = EMIT_CONN;
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/amc_rowmem.sv
// Adjacency row memory with per-row valid bits; unwritten rows read as zero.
module amc_rowmem #(
  parameter int unsigned DEPTH = amc_pkg::MAX_VERTICES_DEF,
  parameter int unsigned WIDTH = amc_pkg::MAX_VERTICES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clr,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  import amc_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [WIDTH-1:0] rd_q_r;
  logic             rvalid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      rvalid_r <= valid_r[raddr];
      if (clr) begin
        valid_r <= '0;
      end else if (we) begin
        valid_r[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rvalid_r ? rd_q_r : {WIDTH{1'b0}};

endmodule

>>> rtl/adjacency_matrix_connectivity.sv
// Top level: graph adjacency matrix with edge commands and a connectivity check.
//
// Usage:
//   Command channel: a word (in_command, in_vertex_a, in_vertex_b) is taken on a
//   rising edge with start high and busy low. busy stays high until the result
//   has been issued.
//   Result channel: one word per command, held on out_* for one cycle with
//   out_strobe high. The receiver cannot stall; results are never held back.
//   Config: cfg_wr_en/cfg_wr_data write vertex_count (0 reads as 1, above
//   MAX_VERTICES saturates) and clear the graph. Write only while idle.
// Sequence (start accepted to out_strobe):
//   range error: dispatch, range check, emit; insert/remove/query: dispatch,
//   range check, read row a, write row a and read row b, write row b and emit.
//   connectivity check: dispatch, init, S sweeps over the rows (N = vertex_count,
//   S at most N), each row read on the single memory read port, driven by the microcode sequencer.
//   Next command may be started the cycle out_strobe is high.
// Reset: matrix, edge count and visit mask cleared; vertex_count = min(32, MAX_VERTICES).
module adjacency_matrix_connectivity #(
  parameter int unsigned MAX_VERTICES = amc_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [amc_pkg::CMD_W-1:0]   in_command,
  input  logic [amc_pkg::VTX_W-1:0]   in_vertex_a,
  input  logic [amc_pkg::VTX_W-1:0]   in_vertex_b,
  output logic                        out_strobe,
  output logic                        out_edge_present,
  output logic                        out_connected,
  output logic [amc_pkg::EDGE_W-1:0]  out_edge_total,
  output logic                        out_vertex_error,
  input  logic                        cfg_wr_en,
  input  logic [amc_pkg::VC_W-1:0]    cfg_wr_data
);
  import amc_pkg::*;

  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned VCW = $clog2(MAX_VERTICES + 1);

  pc_t                 pc_r, pc_nxt;
  ctl_word_t           cw;
  logic                cond_hit;

  cmd_t                cmd_r;
  logic [VTX_W-1:0]    a_r, b_r;
  logic [VCW-1:0]      vc_r;
  logic [EDGE_W-1:0]   edge_cnt_r;
  logic [MAX_VERTICES-1:0] visited_r;
  logic                changed_r;
  logic [VW-1:0]       v_r;
  logic                old_r, chg_r;

  logic                out_strobe_r, out_present_r, out_conn_r, out_err_r;
  logic [EDGE_W-1:0]   out_total_r;

  logic [VW-1:0]       a_idx, b_idx, raddr, waddr;
  logic [MAX_VERTICES-1:0] row, wdata, use_mask, bit_a, bit_b, visited_upd;
  logic                mem_we, vtx_err, is_last, row_old, row_chg, accept;

  assign cw     = ucode(pc_r);
  assign busy   = (pc_r != S_IDLE);
  assign accept = start && !busy;

  assign a_idx = VW'(a_r);
  assign b_idx = VW'(b_r);
  assign bit_a = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << a_idx;
  assign bit_b = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << b_idx;

  assign vtx_err = (int'(a_r) >= int'(vc_r)) || (int'(b_r) >= int'(vc_r));
  assign is_last = (v_r == VW'(vc_r - VCW'(1)));

  always_comb begin
    for (int i = 0; i < int'(MAX_VERTICES); i++) begin
      use_mask[i] = (i < int'(vc_r));
    end
  end

  always_comb begin
    unique case (cw.cond)
      C_NEVER:   cond_hit = 1'b0;
      C_ALWAYS:  cond_hit = 1'b1;
      C_NOSTART: cond_hit = !start;
      C_CHECK:   cond_hit = (cmd_r == CMD_CHECK);
      C_ERR:     cond_hit = vtx_err;
      C_MORE:    cond_hit = !is_last;
      C_CHANGED: cond_hit = changed_r;
      default:   cond_hit = 1'b0;
    endcase
    pc_nxt = cond_hit ? cw.target : pc_r + pc_t'(1);
  end

  always_comb begin
    unique case (cw.rd_sel)
      RD_A:    raddr = a_idx;
      RD_B:    raddr = b_idx;
      RD_V:    raddr = v_r;
      default: raddr = a_idx;
    endcase
  end

  assign row_old = row[b_idx];
  assign row_chg = ((cmd_r == CMD_INSERT) && (a_r != b_r) && !row_old) ||
                   ((cmd_r == CMD_REMOVE) && row_old);

  always_comb begin
    mem_we = 1'b0;
    waddr  = a_idx;
    wdata  = row;
    unique case (cw.wr_sel)
      WR_A: begin
        mem_we = row_chg;
        waddr  = a_idx;
        wdata  = (cmd_r == CMD_INSERT) ? (row | bit_b) : (row & ~bit_b);
      end
      WR_B: begin
        mem_we = chg_r;
        waddr  = b_idx;
        wdata  = (cmd_r == CMD_INSERT) ? (row | bit_a) : (row & ~bit_a);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign visited_upd = visited_r | (row & use_mask);

  amc_rowmem #(
    .DEPTH(MAX_VERTICES),
    .WIDTH(MAX_VERTICES)
  ) u_rowmem (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (cfg_wr_en),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (row)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= S_IDLE;
      vc_r         <= VCW'(VC_RESET > MAX_VERTICES ? MAX_VERTICES : VC_RESET);
      edge_cnt_r   <= '0;
      visited_r    <= '0;
      changed_r    <= 1'b0;
      v_r          <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      pc_r         <= pc_nxt;
      out_strobe_r <= (cw.emit != EMIT_NONE);
      if (cfg_wr_en) begin
        if (int'(cfg_wr_data) > int'(MAX_VERTICES)) begin
          vc_r <= VCW'(MAX_VERTICES);
        end else if (cfg_wr_data == '0) begin
          vc_r <= VCW'(1);
        end else begin
          vc_r <= VCW'(cfg_wr_data);
        end
        edge_cnt_r <= '0;
        visited_r  <= '0;
        changed_r  <= 1'b0;
      end else begin
        if (cw.edge_eval && row_chg) begin
          edge_cnt_r <= (cmd_r == CMD_INSERT) ? edge_cnt_r + EDGE_W'(1)
                                              : edge_cnt_r - EDGE_W'(1);
        end
        if (cw.chk_init) begin
          visited_r <= {{(MAX_VERTICES-1){1'b0}}, 1'b1};
          changed_r <= 1'b0;
          v_r       <= '0;
        end
        if (cw.sweep_acc) begin
          if (visited_r[v_r]) begin
            visited_r <= visited_upd;
            if (visited_upd != visited_r) begin
              changed_r <= 1'b1;
            end
          end
          v_r <= is_last ? '0 : v_r + VW'(1);
        end
        if (cw.chg_clr) begin
          changed_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(in_command);
      a_r   <= in_vertex_a;
      b_r   <= in_vertex_b;
    end
    if (cw.edge_eval) begin
      old_r <= row_old;
      chg_r <= row_chg;
    end
    if (cw.emit != EMIT_NONE) begin
      out_total_r   <= edge_cnt_r;
      out_present_r <= (cw.emit == EMIT_EDGE) &&
                       (chg_r ? (cmd_r == CMD_INSERT) : old_r);
      out_conn_r    <= (cw.emit == EMIT_CONN) && (visited_r == use_mask);
      out_err_r     <= (cw.emit == EMIT_ERR);
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_edge_present = out_present_r;
  assign out_connected    = out_conn_r;
  assign out_edge_total   = out_total_r;
  assign out_vertex_error = out_err_r;

endmodule
